// File: sv/mmet_pkg.sv
// ----------------------------------------------------------------------------
// mmet_pkg: shared constants and types for the edge timestamp core
// Channel count, filter window length and the timestamp widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mmet_pkg;

  localparam int NUM_CH      = 4;
  localparam int CH_W        = 2;
  localparam int WINDOW_LEN  = 8;
  localparam int STAMP_WIDTH = 16;
  localparam int TIME_W      = 16;
  // bits of the timer that can survive both the stamp mask and the field width
  localparam int STAMP_KEEP  = (STAMP_WIDTH < TIME_W) ? STAMP_WIDTH : TIME_W;

  typedef struct packed {
    logic filt;  // filtered level after this tick
    logic fall;  // filtered level fell 1 -> 0 on this tick
  } lane_stat_t;

endpackage

`default_nettype wire

// File: sv/mmet_lane.sv
// ----------------------------------------------------------------------------
// mmet_lane: one channel of glitch filter, edge detect and timer capture
// Shifts the pin sample into a window, ANDs the window, flags a falling
// filtered level and latches the timer on that edge.
// ----------------------------------------------------------------------------
`default_nettype none

module mmet_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              level_i,
  input  wire logic [mmet_pkg::TIME_W-1:0]       time_i,
  output mmet_pkg::lane_stat_t                   stat_o,
  output logic      [mmet_pkg::STAMP_KEEP-1:0]   stamp_o
);

  logic [mmet_pkg::WINDOW_LEN-1:0] hist_q, hist_d;
  logic                            filt_q, filt_d;
  logic [mmet_pkg::STAMP_KEEP-1:0] stamp_q;
  logic                            fall;

  generate
    if (mmet_pkg::WINDOW_LEN == 1) begin : g_single
      assign hist_d = level_i;
    end else begin : g_shift
      assign hist_d = {hist_q[mmet_pkg::WINDOW_LEN-2:0], level_i};
    end
  endgenerate

  assign filt_d = &hist_d;
  assign fall   = filt_q & ~filt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '1;
      filt_q  <= 1'b0;
      stamp_q <= '0;
    end else if (accept_i) begin
      hist_q <= hist_d;
      filt_q <= filt_d;
      if (fall) begin
        stamp_q <= time_i[mmet_pkg::STAMP_KEEP-1:0];
      end
    end
  end

  assign stat_o.filt = filt_q;
  assign stat_o.fall = fall;
  assign stamp_o     = stamp_q;

endmodule

`default_nettype wire

// File: sv/mmet_merge.sv
// ----------------------------------------------------------------------------
// mmet_merge: arrival order of falling edges across all lanes
// Appends edge channels lowest first into a four-slot order and counts
// arrivals; flags the tick on which the round wraps.
// ----------------------------------------------------------------------------
`default_nettype none

module mmet_merge (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          accept_i,
  input  wire logic [mmet_pkg::NUM_CH-1:0]                   fall_i,
  output logic      [mmet_pkg::NUM_CH*mmet_pkg::CH_W-1:0]    order_o,
  output logic      [mmet_pkg::CH_W-1:0]                     fill_o,
  output logic                                               done_o
);

  logic [mmet_pkg::NUM_CH-1:0][mmet_pkg::CH_W-1:0] slots_q, slots_d;
  logic [mmet_pkg::CH_W-1:0]                       fill_q, fill_d;
  logic                                            done;

  // several edges in one tick may wrap the round part-way through
  always_comb begin
    slots_d = slots_q;
    fill_d  = fill_q;
    done    = 1'b0;
    for (int c = 0; c < mmet_pkg::NUM_CH; c++) begin
      if (fall_i[c]) begin
        slots_d[fill_d] = mmet_pkg::CH_W'(c);
        fill_d          = fill_d + 1'b1;
        if (fill_d == '0) begin
          done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
      fill_q  <= '0;
    end else if (accept_i) begin
      slots_q <= slots_d;
      fill_q  <= fill_d;
    end
  end

  assign order_o = slots_q;
  assign fill_o  = fill_q;
  assign done_o  = done;

endmodule

`default_nettype wire

// File: sv/multi_mic_edge_timestamp_core.sv
// ----------------------------------------------------------------------------
// multi_mic_edge_timestamp_core: four-channel filtered input capture
// Glitch filter per channel, falling-edge timer capture and arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one word per sample tick (mic_levels_i, time_now_i),
//   taken when in_valid_i is high and in_stall_o is low.
//   Output channel: one word per input word, presented with out_valid_o and
//   taken when out_stall_i is low.
//   The result of a word taken at a clock edge is valid after that same
//   edge. Throughput is one word per cycle while the receiver does not stall;
//   the four lanes and the order merge all settle combinationally between
//   the input handshake and the output register.
//   When the receiver stalls, the result holds and in_stall_o rises while
//   the output register is full and stalled; it drops in the cycle the
//   word is taken, so a new word can be taken in that same cycle.
//   Reset sets every window to all ones, clears the previous filtered
//   levels, the timer captures, the order slots and the count, and empties
//   the output register. No clearing pass; the block takes words at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_mic_edge_timestamp_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  mic_levels_i,
  input  wire logic [15:0] time_now_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       filtered_levels_o,
  output logic [3:0]       falling_edges_o,
  output logic [7:0]       arrival_order_o,
  output logic [1:0]       arrival_count_o,
  output logic             round_done_o,
  output logic [15:0]      stamp_ch0_o,
  output logic [15:0]      stamp_ch1_o,
  output logic [15:0]      stamp_ch2_o,
  output logic [15:0]      stamp_ch3_o
);

  mmet_pkg::lane_stat_t                   stat  [mmet_pkg::NUM_CH];
  logic [mmet_pkg::STAMP_KEEP-1:0]        stamp [mmet_pkg::NUM_CH];
  logic [mmet_pkg::NUM_CH-1:0]            falls;
  logic [mmet_pkg::NUM_CH-1:0]            filts;
  logic                                   in_acc;
  logic                                   done;
  logic                                   out_valid_q, out_valid_d;
  logic [mmet_pkg::NUM_CH-1:0]            edges_q;
  logic                                   done_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  generate
    for (genvar c = 0; c < mmet_pkg::NUM_CH; c++) begin : g_lane
      mmet_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .accept_i (in_acc),
        .level_i  (mic_levels_i[c]),
        .time_i   (time_now_i),
        .stat_o   (stat[c]),
        .stamp_o  (stamp[c])
      );
      assign falls[c] = stat[c].fall;
      assign filts[c] = stat[c].filt;
    end
  endgenerate

  mmet_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .fall_i   (falls),
    .order_o  (arrival_order_o),
    .fill_o   (arrival_count_o),
    .done_o   (done)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      edges_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        edges_q <= falls;
        done_q  <= done;
      end
    end
  end

  // lane state only moves on a taken input word, so it doubles as payload
  assign out_valid_o       = out_valid_q;
  assign filtered_levels_o = filts;
  assign falling_edges_o   = edges_q;
  assign round_done_o      = done_q;
  assign stamp_ch0_o       = 16'(stamp[0]);
  assign stamp_ch1_o       = 16'(stamp[1]);
  assign stamp_ch2_o       = 16'(stamp[2]);
  assign stamp_ch3_o       = 16'(stamp[3]);

`ifndef SYNTHESIS
  a_edge_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((falling_edges_o & filtered_levels_o) == 4'd0))
    else $error("edge reported on a channel still filtered high");

  a_done_needs_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && round_done_o) |-> (falling_edges_o != 4'd0))
    else $error("round done without any falling edge");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (falls == '0)) |=> (arrival_count_o == $past(arrival_count_o)))
    else $error("arrival count moved without an edge");
`endif

endmodule

`default_nettype wire
